/* rtl/tlr_pkg.sv */
// ----------------------------------------------------------------------------
// Text line refresher package
// Shared command word, operation codes and panel bus constants.
// ----------------------------------------------------------------------------
package tlr_pkg;

    typedef enum logic [2:0] {
        OP_WRITE  = 3'd0,
        OP_COMMIT = 3'd1,
        OP_CLEAR  = 3'd2,
        OP_FONT   = 3'd3,
        OP_STEP   = 3'd4
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [2:0]  line;
        logic [4:0]  column;
        logic [7:0]  char_code;
        logic [4:0]  length;
        logic [2:0]  attr;
        logic [2:0]  glyph_column;
        logic [7:0]  font_byte;
    } t_cmd;

    localparam logic [1:0] BK_DATA   = 2'd0;
    localparam logic [1:0] BK_PAGE   = 2'd1;
    localparam logic [1:0] BK_COLUMN = 2'd2;

    localparam logic [1:0] CS_LEFT  = 2'd1;
    localparam logic [1:0] CS_RIGHT = 2'd2;
    localparam logic [1:0] CS_BOTH  = 2'd3;

    localparam int ATTR_CENTER   = 0;
    localparam int ATTR_INV_TEXT = 1;
    localparam int ATTR_INV_ALL  = 2;

    localparam int PANEL_WIDTH = 128;
    localparam int HALF_WIDTH  = 64;
    localparam int POS_W       = 7;
    localparam int CHAR_IDX_W  = 5;

    localparam logic [7:0] FILL_ON  = 8'hFF;
    localparam logic [7:0] FILL_OFF = 8'h00;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;

endpackage

/* rtl/text_line_display_refresher.sv */
// ----------------------------------------------------------------------------
// Text line display refresher top level
// The input takes one word per cycle while the four-entry queue has room, and the back end
// retires one queued non-step word per cycle while idle. A step that sends a command word
// loads it into the output registers as it is popped; a step that sends a pixel column
// passes the index, glyph and emit states, set by the chained text and font store reads,
// and holds the back end until loaded. Reset clears all lines, attributes and flags only.
// ----------------------------------------------------------------------------
module text_line_display_refresher #(
    parameter int LINE_COUNT     = 8,
    parameter int CHARS_PER_LINE = 21,
    parameter int GLYPH_WIDTH    = 6
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_op,
    input  logic [2:0]  i_line,
    input  logic [4:0]  i_column,
    input  logic [7:0]  i_char_code,
    input  logic [4:0]  i_line_length,
    input  logic        i_center,
    input  logic        i_invert_text,
    input  logic        i_invert_all,
    input  logic [2:0]  i_glyph_column,
    input  logic [7:0]  i_font_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_bus_kind,
    output logic [1:0]  o_chip_select,
    output logic [7:0]  o_byte_value
);

    tlr_pkg::t_cmd w_cmd;
    logic          w_cmd_valid;
    logic          w_cmd_pop;

    tlr_front #(
        .LINE_COUNT     (LINE_COUNT),
        .CHARS_PER_LINE (CHARS_PER_LINE),
        .GLYPH_WIDTH    (GLYPH_WIDTH)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_op           (i_op),
        .i_line         (i_line),
        .i_column       (i_column),
        .i_char_code    (i_char_code),
        .i_line_length  (i_line_length),
        .i_center       (i_center),
        .i_invert_text  (i_invert_text),
        .i_invert_all   (i_invert_all),
        .i_glyph_column (i_glyph_column),
        .i_font_byte    (i_font_byte),
        .o_cmd          (w_cmd),
        .o_cmd_valid    (w_cmd_valid),
        .i_cmd_pop      (w_cmd_pop)
    );

    tlr_back #(
        .LINE_COUNT  (LINE_COUNT),
        .GLYPH_WIDTH (GLYPH_WIDTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_cmd_valid   (w_cmd_valid),
        .o_cmd_pop     (w_cmd_pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_bus_kind    (o_bus_kind),
        .o_chip_select (o_chip_select),
        .o_byte_value  (o_byte_value)
    );

    a_pop_needs_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd_pop |-> w_cmd_valid)
        else $error("Queue popped while empty.");

    a_page_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_bus_kind == tlr_pkg::BK_PAGE) |-> (o_byte_value < 8'(LINE_COUNT)))
        else $error("Set-page word names a line that does not exist.");

    a_column_cmd_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_bus_kind == tlr_pkg::BK_COLUMN) |->
        (o_chip_select == tlr_pkg::CS_BOTH && o_byte_value == 8'h00))
        else $error("Set-column word is malformed.");

    a_data_one_chip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_bus_kind == tlr_pkg::BK_DATA) |->
        (o_chip_select == tlr_pkg::CS_LEFT || o_chip_select == tlr_pkg::CS_RIGHT))
        else $error("Pixel word addressed to both chips.");

endmodule

/* rtl/tlr_front.sv */
// ----------------------------------------------------------------------------
// Text line refresher front end
// Accepts words, drops those that do nothing and queues the rest in order.
// ----------------------------------------------------------------------------
module tlr_front #(
    parameter int LINE_COUNT     = 8,
    parameter int CHARS_PER_LINE = 21,
    parameter int GLYPH_WIDTH    = 6
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [2:0]        i_op,
    input  logic [2:0]        i_line,
    input  logic [4:0]        i_column,
    input  logic [7:0]        i_char_code,
    input  logic [4:0]        i_line_length,
    input  logic              i_center,
    input  logic              i_invert_text,
    input  logic              i_invert_all,
    input  logic [2:0]        i_glyph_column,
    input  logic [7:0]        i_font_byte,
    output tlr_pkg::t_cmd     o_cmd,
    output logic              o_cmd_valid,
    input  logic              i_cmd_pop
);

    tlr_pkg::t_cmd                 w_cmd;
    logic                          w_keep;
    logic                          w_push;

    tlr_pkg::t_cmd                 r_q [tlr_pkg::Q_DEPTH];
    logic [tlr_pkg::Q_PTR_W-1:0]   r_wr, n_wr;
    logic [tlr_pkg::Q_PTR_W-1:0]   r_rd, n_rd;
    logic [tlr_pkg::Q_PTR_W:0]     r_count, n_count;

    always_comb begin
        w_cmd.op           = tlr_pkg::t_op'(i_op);
        w_cmd.line         = i_line;
        w_cmd.column       = i_column;
        w_cmd.char_code    = i_char_code;
        w_cmd.length       = (i_line_length > 5'(CHARS_PER_LINE)) ?
                             5'(CHARS_PER_LINE) : i_line_length;
        w_cmd.attr         = {i_invert_all, i_invert_text, i_center};
        w_cmd.glyph_column = i_glyph_column;
        w_cmd.font_byte    = i_font_byte;
    end

    always_comb begin
        unique case (tlr_pkg::t_op'(i_op))
            tlr_pkg::OP_WRITE: begin
                w_keep = (4'(i_line) < 4'(LINE_COUNT)) &&
                         (6'(i_column) < 6'(CHARS_PER_LINE));
            end
            tlr_pkg::OP_COMMIT: begin
                w_keep = 4'(i_line) < 4'(LINE_COUNT);
            end
            tlr_pkg::OP_CLEAR: begin
                w_keep = 1'b1;
            end
            tlr_pkg::OP_FONT: begin
                w_keep = 4'(i_glyph_column) < 4'(GLYPH_WIDTH);
            end
            tlr_pkg::OP_STEP: begin
                w_keep = 1'b1;
            end
            default: begin
                w_keep = 1'b0;
            end
        endcase
    end

    assign o_ready     = r_count != (tlr_pkg::Q_PTR_W + 1)'(tlr_pkg::Q_DEPTH);
    assign w_push      = i_valid && o_ready && w_keep;
    assign o_cmd       = r_q[r_rd];
    assign o_cmd_valid = r_count != '0;

    always_comb begin
        n_wr    = w_push ? r_wr + 1'b1 : r_wr;
        n_rd    = i_cmd_pop ? r_rd + 1'b1 : r_rd;
        n_count = r_count;
        if (w_push && !i_cmd_pop) begin
            n_count = r_count + 1'b1;
        end else if (!w_push && i_cmd_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr] <= w_cmd;
        end
    end

endmodule

/* rtl/tlr_back.sv */
// ----------------------------------------------------------------------------
// Text line refresher back end
// Executes queued commands, holds the line and font stores and forms the
// panel bus words through a short pipeline of store reads.
// ----------------------------------------------------------------------------
module tlr_back #(
    parameter int LINE_COUNT  = 8,
    parameter int GLYPH_WIDTH = 6
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  tlr_pkg::t_cmd  i_cmd,
    input  logic           i_cmd_valid,
    output logic           o_cmd_pop,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [1:0]     o_bus_kind,
    output logic [1:0]     o_chip_select,
    output logic [7:0]     o_byte_value
);

    localparam int LIDX_W      = (LINE_COUNT > 1) ? $clog2(LINE_COUNT) : 1;
    localparam int GC_W        = (GLYPH_WIDTH > 1) ? $clog2(GLYPH_WIDTH) : 1;
    localparam int TEXT_AW     = LIDX_W + tlr_pkg::CHAR_IDX_W;
    localparam int TEXT_DEPTH  = 2 ** TEXT_AW;
    localparam int GLYPH_AW    = 8 + GC_W;
    localparam int GLYPH_DEPTH = 2 ** GLYPH_AW;
    localparam int RECIP_SHIFT = 16;
    localparam logic [16:0] RECIP = 17'((2 ** RECIP_SHIFT + GLYPH_WIDTH - 1) / GLYPH_WIDTH);
    localparam int PW = tlr_pkg::POS_W;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_KIDX  = 4'b0010,
        S_GLYPH = 4'b0100,
        S_EMIT  = 4'b1000
    } t_state;

    t_state              r_state, n_state;
    logic [4:0]          r_len  [LINE_COUNT];
    logic [4:0]          n_len  [LINE_COUNT];
    logic [2:0]          r_attr [LINE_COUNT];
    logic [2:0]          n_attr [LINE_COUNT];
    logic [LINE_COUNT-1:0] r_dirty, n_dirty;
    logic                r_act_valid, n_act_valid;
    logic [LIDX_W-1:0]   r_act_line, n_act_line;
    logic                r_addr_pend, n_addr_pend;
    logic [PW-1:0]       r_pos, n_pos;

    logic [PW-1:0]       r_off, n_off;
    logic                r_in_glyph, n_in_glyph;
    logic                r_pad, n_pad;
    logic                r_inv, n_inv;
    logic [PW-1:0]       r_k;
    logic [7:0]          r_tdata;
    logic [7:0]          r_gdata;

    logic                r_out_valid;
    logic [1:0]          r_out_kind, n_out_kind;
    logic [1:0]          r_out_cs, n_out_cs;
    logic [7:0]          r_out_byte, n_out_byte;

    logic [7:0]          r_text_mem  [TEXT_DEPTH];
    logic [7:0]          r_glyph_mem [GLYPH_DEPTH];

    logic                w_out_free;
    logic                w_out_load;
    logic                w_text_we;
    logic                w_glyph_we;
    logic                w_found;
    logic [LIDX_W-1:0]   w_first;
    logic [LIDX_W-1:0]   w_cmd_line;
    logic [4:0]          w_len;
    logic [2:0]          w_attr;
    logic [7:0]          w_span;
    logic [PW-1:0]       w_half;
    logic [PW-1:0]       w_start;
    logic [8:0]          w_end;
    logic [23:0]         w_prod;
    logic [PW-1:0]       w_k;
    logic [9:0]          w_kg;
    logic [9:0]          w_cfull;
    logic [GC_W-1:0]     w_c;
    logic [7:0]          w_glyph_byte;
    logic [7:0]          w_data_byte;

    assign w_out_free = !r_out_valid || i_ready;
    assign w_cmd_line = i_cmd.line[LIDX_W-1:0];

    always_comb begin
        w_found = 1'b0;
        w_first = '0;
        for (int i = LINE_COUNT - 1; i >= 0; i--) begin
            if (r_dirty[i]) begin
                w_found = 1'b1;
                w_first = LIDX_W'(i);
            end
        end
    end

    // Placement of the current pixel column within the line layout.
    assign w_len   = r_len[r_act_line];
    assign w_attr  = r_attr[r_act_line];
    assign w_span  = 8'(w_len * GLYPH_WIDTH);
    assign w_half  = w_span[7:1];
    assign w_start = (!w_attr[tlr_pkg::ATTR_CENTER] || w_half >= PW'(tlr_pkg::HALF_WIDTH)) ?
                     '0 : PW'(tlr_pkg::HALF_WIDTH) - w_half;
    assign w_end   = 9'(w_start) + 9'(w_span);

    // Character index by reciprocal multiplication, then column within glyph.
    assign w_prod  = 24'(r_off) * 24'(RECIP);
    assign w_k     = w_prod[RECIP_SHIFT +: PW];
    assign w_kg    = 10'(r_k) * 10'(GLYPH_WIDTH);
    assign w_cfull = 10'(r_off) - w_kg;
    assign w_c     = w_cfull[GC_W-1:0];

    assign w_glyph_byte = r_inv ? ~r_gdata : r_gdata;
    assign w_data_byte  = r_in_glyph ? w_glyph_byte :
                          (r_pad ? tlr_pkg::FILL_ON : tlr_pkg::FILL_OFF);

    always_comb begin
        n_state     = r_state;
        n_len       = r_len;
        n_attr      = r_attr;
        n_dirty     = r_dirty;
        n_act_valid = r_act_valid;
        n_act_line  = r_act_line;
        n_addr_pend = r_addr_pend;
        n_pos       = r_pos;
        n_off       = r_off;
        n_in_glyph  = r_in_glyph;
        n_pad       = r_pad;
        n_inv       = r_inv;
        n_out_kind  = r_out_kind;
        n_out_cs    = r_out_cs;
        n_out_byte  = r_out_byte;
        w_out_load  = 1'b0;
        w_text_we   = 1'b0;
        w_glyph_we  = 1'b0;
        o_cmd_pop   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    unique case (i_cmd.op)
                        tlr_pkg::OP_WRITE: begin
                            o_cmd_pop = 1'b1;
                            w_text_we = 1'b1;
                        end
                        tlr_pkg::OP_COMMIT: begin
                            o_cmd_pop           = 1'b1;
                            n_len[w_cmd_line]   = i_cmd.length;
                            n_attr[w_cmd_line]  = i_cmd.attr;
                            n_dirty[w_cmd_line] = 1'b1;
                        end
                        tlr_pkg::OP_CLEAR: begin
                            o_cmd_pop = 1'b1;
                            for (int i = 0; i < LINE_COUNT; i++) begin
                                n_len[i]  = '0;
                                n_attr[i] = '0;
                            end
                            n_dirty = '1;
                        end
                        tlr_pkg::OP_FONT: begin
                            o_cmd_pop  = 1'b1;
                            w_glyph_we = 1'b1;
                        end
                        tlr_pkg::OP_STEP: begin
                            priority if (!r_act_valid) begin
                                if (!w_found) begin
                                    o_cmd_pop = 1'b1;
                                end else if (w_out_free) begin
                                    o_cmd_pop   = 1'b1;
                                    w_out_load  = 1'b1;
                                    n_out_kind  = tlr_pkg::BK_PAGE;
                                    n_out_cs    = tlr_pkg::CS_BOTH;
                                    n_out_byte  = 8'(w_first);
                                    n_act_valid = 1'b1;
                                    n_act_line  = w_first;
                                    n_addr_pend = 1'b1;
                                    n_pos       = '0;
                                end
                            end else if (r_addr_pend) begin
                                if (w_out_free) begin
                                    o_cmd_pop   = 1'b1;
                                    w_out_load  = 1'b1;
                                    n_out_kind  = tlr_pkg::BK_COLUMN;
                                    n_out_cs    = tlr_pkg::CS_BOTH;
                                    n_out_byte  = 8'h00;
                                    n_addr_pend = 1'b0;
                                end
                            end else begin
                                o_cmd_pop  = 1'b1;
                                n_off      = r_pos - w_start;
                                n_in_glyph = (r_pos >= w_start) && (9'(r_pos) < w_end);
                                n_pad      = w_attr[tlr_pkg::ATTR_INV_ALL];
                                n_inv      = w_attr[tlr_pkg::ATTR_INV_ALL] ||
                                             w_attr[tlr_pkg::ATTR_INV_TEXT];
                                n_state    = S_KIDX;
                            end
                        end
                        default: begin
                            o_cmd_pop = 1'b1;
                        end
                    endcase
                end
            end
            S_KIDX: begin
                n_state = S_GLYPH;
            end
            S_GLYPH: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (w_out_free) begin
                    w_out_load = 1'b1;
                    n_out_kind = tlr_pkg::BK_DATA;
                    n_out_cs   = (r_pos < PW'(tlr_pkg::HALF_WIDTH)) ?
                                 tlr_pkg::CS_LEFT : tlr_pkg::CS_RIGHT;
                    n_out_byte = w_data_byte;
                    n_pos      = r_pos + 1'b1;
                    if (r_pos == PW'(tlr_pkg::PANEL_WIDTH - 1)) begin
                        n_dirty[r_act_line] = 1'b0;
                        n_act_valid         = 1'b0;
                        n_pos               = '0;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_dirty     <= '0;
            r_act_valid <= 1'b0;
            r_act_line  <= '0;
            r_addr_pend <= 1'b0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < LINE_COUNT; i++) begin
                r_len[i]  <= '0;
                r_attr[i] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_dirty     <= n_dirty;
            r_act_valid <= n_act_valid;
            r_act_line  <= n_act_line;
            r_addr_pend <= n_addr_pend;
            r_pos       <= n_pos;
            r_len       <= n_len;
            r_attr      <= n_attr;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_off      <= n_off;
        r_in_glyph <= n_in_glyph;
        r_pad      <= n_pad;
        r_inv      <= n_inv;
        r_out_kind <= n_out_kind;
        r_out_cs   <= n_out_cs;
        r_out_byte <= n_out_byte;
        if (r_state == S_KIDX) begin
            r_k <= w_k;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_text_we) begin
            r_text_mem[{w_cmd_line, i_cmd.column}] <= i_cmd.char_code;
        end
        r_tdata <= r_text_mem[{r_act_line, w_k[tlr_pkg::CHAR_IDX_W-1:0]}];
    end

    always_ff @(posedge i_clk) begin
        if (w_glyph_we) begin
            r_glyph_mem[{i_cmd.char_code, i_cmd.glyph_column[GC_W-1:0]}] <= i_cmd.font_byte;
        end
        r_gdata <= r_glyph_mem[{r_tdata, w_c}];
    end

    assign o_valid       = r_out_valid;
    assign o_bus_kind    = r_out_kind;
    assign o_chip_select = r_out_cs;
    assign o_byte_value  = r_out_byte;

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text line display refresher testbench
// Drives command words through the input handshake and checks every panel bus
// word against a cycle-free model of the refresher. A short scripted pass
// covers reset, the extremes and the odd cases. Random line jobs, font loads
// and step bursts follow under changing sender and receiver idling.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int LINES           = 8;
    localparam int CHARS           = 21;
    localparam int GLYPH_W         = 6;
    localparam int MAX_LEN         = 31;
    localparam int MAX_GCOL        = 7;
    localparam int ITEMS_PER_PHASE = 320;
    localparam int SETTLE_CYCLES   = 16;
    localparam int REPORT_LIMIT    = 10;

    localparam logic [3:0] NO_ROW = 4'd8;
    localparam logic [2:0] OP_RSVD_FIRST = 3'd5;
    localparam logic [2:0] OP_RSVD_LAST  = 3'd7;
    localparam logic [2:0] A_CENTER   = 3'(1 << tlr_pkg::ATTR_CENTER);
    localparam logic [2:0] A_INV_TEXT = 3'(1 << tlr_pkg::ATTR_INV_TEXT);
    localparam logic [2:0] A_INV_ALL  = 3'(1 << tlr_pkg::ATTR_INV_ALL);
    localparam logic [GLYPH_W-1:0] FULL_GLYPH = {GLYPH_W{1'b1}};

    typedef struct packed {
        logic [2:0] op;
        logic [2:0] line;
        logic [4:0] column;
        logic [7:0] char_code;
        logic [4:0] line_length;
        logic       center;
        logic       invert_text;
        logic       invert_all;
        logic [2:0] glyph_column;
        logic [7:0] font_byte;
    } t_panel_cmd;

    typedef struct packed {
        logic [1:0] kind;
        logic [1:0] cs;
        logic [7:0] val;
    } t_bus_word;

    typedef struct packed {
        t_panel_cmd cmd;
        logic [7:0] reps;
        logic       given;
        t_bus_word  word;
    } t_script_row;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_ready;
    logic [2:0] i_op = tlr_pkg::OP_STEP;
    logic [2:0] i_line = '0;
    logic [4:0] i_column = '0;
    logic [7:0] i_char_code = '0;
    logic [4:0] i_line_length = '0;
    logic       i_center = 1'b0;
    logic       i_invert_text = 1'b0;
    logic       i_invert_all = 1'b0;
    logic [2:0] i_glyph_column = '0;
    logic [7:0] i_font_byte = '0;
    logic       o_valid;
    logic       i_ready = 1'b0;
    logic [1:0] o_bus_kind;
    logic [1:0] o_chip_select;
    logic [7:0] o_byte_value;

    logic      given_on = 1'b0;
    t_bus_word given_word = '0;

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int mismatches = 0;
    int useful_items = 0;
    int bus_words_checked = 0;
    int lines_refreshed = 0;

    logic [7:0] row_chars [LINES][CHARS];
    logic [4:0] row_len [LINES];
    logic [2:0] row_attr [LINES];
    logic [7:0] row_dirty;
    logic [7:0] font_mem [256*GLYPH_W];
    logic [3:0] active_row;
    logic       page_due;
    logic       addr_due;
    logic [7:0] pixel_pos;

    t_bus_word bus_words_due [$];

    logic [CHARS-1:0]   chars_set [LINES];
    logic [GLYPH_W-1:0] glyph_cols_seen [256];
    logic [7:0]         ready_codes [$];
    t_script_row        script [$];

    text_line_display_refresher dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_op           (i_op),
        .i_line         (i_line),
        .i_column       (i_column),
        .i_char_code    (i_char_code),
        .i_line_length  (i_line_length),
        .i_center       (i_center),
        .i_invert_text  (i_invert_text),
        .i_invert_all   (i_invert_all),
        .i_glyph_column (i_glyph_column),
        .i_font_byte    (i_font_byte),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_bus_kind     (o_bus_kind),
        .o_chip_select  (o_chip_select),
        .o_byte_value   (o_byte_value)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    function automatic logic [7:0] column_pixels(int ln, int p);
        int span;
        int start;
        int off;
        logic [7:0] pad;
        logic [7:0] g;
        span = int'(row_len[ln]) * GLYPH_W;
        start = 0;
        pad = row_attr[ln][tlr_pkg::ATTR_INV_ALL] ?
              tlr_pkg::FILL_ON : tlr_pkg::FILL_OFF;
        if (row_attr[ln][tlr_pkg::ATTR_CENTER]) begin
            start = (span / 2 >= tlr_pkg::HALF_WIDTH) ? 0 : tlr_pkg::HALF_WIDTH - span / 2;
        end
        if (p < start || p >= start + span) begin
            return pad;
        end
        off = p - start;
        g = font_mem[int'(row_chars[ln][off / GLYPH_W]) * GLYPH_W + off % GLYPH_W];
        if (row_attr[ln][tlr_pkg::ATTR_INV_TEXT] || row_attr[ln][tlr_pkg::ATTR_INV_ALL]) begin
            g = ~g;
        end
        return g;
    endfunction

    function automatic bit panel_bus_predict(t_panel_cmd c, output t_bus_word w);
        int i;
        logic [2:0] a;
        w = '0;
        case (c.op)
            tlr_pkg::OP_WRITE: begin
                if (c.column < CHARS) begin
                    row_chars[c.line][c.column] = c.char_code;
                end
                return 1'b0;
            end
            tlr_pkg::OP_COMMIT: begin
                a = '0;
                a[tlr_pkg::ATTR_CENTER] = c.center;
                a[tlr_pkg::ATTR_INV_TEXT] = c.invert_text;
                a[tlr_pkg::ATTR_INV_ALL] = c.invert_all;
                row_len[c.line] = (c.line_length > CHARS) ? 5'(CHARS) : c.line_length;
                row_attr[c.line] = a;
                row_dirty[c.line] = 1'b1;
                return 1'b0;
            end
            tlr_pkg::OP_CLEAR: begin
                for (i = 0; i < LINES; i++) begin
                    row_len[i] = '0;
                    row_attr[i] = '0;
                end
                row_dirty = '1;
                return 1'b0;
            end
            tlr_pkg::OP_FONT: begin
                if (c.glyph_column < GLYPH_W) begin
                    font_mem[int'(c.char_code) * GLYPH_W + int'(c.glyph_column)] =
                        c.font_byte;
                end
                return 1'b0;
            end
            tlr_pkg::OP_STEP: begin
            end
            default: return 1'b0;
        endcase

        if (active_row >= LINES && !page_due && !addr_due) begin
            if (row_dirty == '0) begin
                return 1'b0;
            end
            for (i = LINES - 1; i >= 0; i--) begin
                if (row_dirty[i]) begin
                    active_row = 4'(i);
                end
            end
            page_due = 1'b1;
            addr_due = 1'b1;
            pixel_pos = '0;
        end
        if (page_due) begin
            page_due = 1'b0;
            w = '{tlr_pkg::BK_PAGE, tlr_pkg::CS_BOTH, 8'(active_row)};
            return 1'b1;
        end
        if (addr_due) begin
            addr_due = 1'b0;
            w = '{tlr_pkg::BK_COLUMN, tlr_pkg::CS_BOTH, 8'd0};
            return 1'b1;
        end
        if (active_row >= LINES) begin
            return 1'b0;
        end
        w.kind = tlr_pkg::BK_DATA;
        w.cs = (pixel_pos < tlr_pkg::HALF_WIDTH) ? tlr_pkg::CS_LEFT : tlr_pkg::CS_RIGHT;
        w.val = column_pixels(int'(active_row), int'(pixel_pos));
        pixel_pos = pixel_pos + 8'd1;
        if (pixel_pos >= tlr_pkg::PANEL_WIDTH) begin
            row_dirty[active_row] = 1'b0;
            active_row = NO_ROW;
            pixel_pos = '0;
            lines_refreshed++;
        end
        return 1'b1;
    endfunction

    task automatic report_mismatch(string what, t_bus_word want, t_bus_word got);
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
            $display("%0t: %s: expected kind %0d cs %0d byte %02h, got kind %0d cs %0d byte %02h",
                     $time, what, want.kind, want.cs, want.val, got.kind, got.cs, got.val);
        end
    endtask

    always @(posedge i_clk) begin : bus_check
        t_panel_cmd c;
        t_bus_word  w;
        t_bus_word  got;
        t_bus_word  want;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                c = '{i_op, i_line, i_column, i_char_code, i_line_length, i_center,
                      i_invert_text, i_invert_all, i_glyph_column, i_font_byte};
                if (panel_bus_predict(c, w)) begin
                    bus_words_due.push_back(given_on ? given_word : w);
                end
            end
            if (o_valid && i_ready) begin
                got = '{o_bus_kind, o_chip_select, o_byte_value};
                bus_words_checked++;
                if (bus_words_due.size() == 0) begin
                    report_mismatch("bus word with nothing expected", '0, got);
                end else begin
                    want = bus_words_due.pop_front();
                    if (got.kind !== want.kind || got.cs !== want.cs || got.val !== want.val) begin
                        report_mismatch("bus word differs", want, got);
                    end
                end
            end
        end
    end

    task automatic send_cmd(t_panel_cmd c, logic given, t_bus_word word);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_op <= c.op;
        i_line <= c.line;
        i_column <= c.column;
        i_char_code <= c.char_code;
        i_line_length <= c.line_length;
        i_center <= c.center;
        i_invert_text <= c.invert_text;
        i_invert_all <= c.invert_all;
        i_glyph_column <= c.glyph_column;
        i_font_byte <= c.font_byte;
        given_on <= given;
        given_word <= word;
        @(posedge i_clk);
        while (!o_ready) begin
            @(posedge i_clk);
        end
        if (c.op == tlr_pkg::OP_WRITE && c.column < CHARS) begin
            chars_set[c.line][c.column] = 1'b1;
        end
        if (c.op == tlr_pkg::OP_FONT && c.glyph_column < GLYPH_W &&
            glyph_cols_seen[c.char_code] != FULL_GLYPH) begin
            glyph_cols_seen[c.char_code][c.glyph_column] = 1'b1;
            if (glyph_cols_seen[c.char_code] == FULL_GLYPH) begin
                ready_codes.push_back(c.char_code);
            end
        end
        if (!(c.op > tlr_pkg::OP_STEP || (c.op == tlr_pkg::OP_WRITE && c.column >= CHARS) ||
              (c.op == tlr_pkg::OP_FONT && c.glyph_column >= GLYPH_W))) begin
            useful_items++;
        end
    endtask

    task automatic hold_until_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (bus_words_due.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    function automatic t_script_row plain_row(logic [2:0] op, int ln, int col, int code,
                                              int len, logic [2:0] attr, int gcol,
                                              int fbyte, int reps);
        t_script_row r;
        r = '0;
        r.cmd.op = op;
        r.cmd.line = 3'(ln);
        r.cmd.column = 5'(col);
        r.cmd.char_code = 8'(code);
        r.cmd.line_length = 5'(len);
        r.cmd.center = attr[tlr_pkg::ATTR_CENTER];
        r.cmd.invert_text = attr[tlr_pkg::ATTR_INV_TEXT];
        r.cmd.invert_all = attr[tlr_pkg::ATTR_INV_ALL];
        r.cmd.glyph_column = 3'(gcol);
        r.cmd.font_byte = 8'(fbyte);
        r.reps = 8'(reps);
        return r;
    endfunction

    function automatic t_script_row typed_steps(int reps, logic [1:0] kind, logic [1:0] cs,
                                               logic [7:0] val);
        t_script_row r;
        r = plain_row(tlr_pkg::OP_STEP, 0, 0, 0, 0, '0, 0, 0, reps);
        r.given = 1'b1;
        r.word = '{kind, cs, val};
        return r;
    endfunction

    function automatic t_panel_cmd noise_cmd();
        t_panel_cmd c;
        c.op = tlr_pkg::OP_STEP;
        c.line = 3'($urandom_range(0, LINES - 1));
        c.column = 5'($urandom_range(0, MAX_LEN));
        c.char_code = 8'($urandom_range(0, 255));
        c.line_length = 5'($urandom_range(0, MAX_LEN));
        c.center = 1'($urandom_range(0, 1));
        c.invert_text = 1'($urandom_range(0, 1));
        c.invert_all = 1'($urandom_range(0, 1));
        c.glyph_column = 3'($urandom_range(0, MAX_GCOL));
        c.font_byte = 8'($urandom_range(0, 255));
        return c;
    endfunction

    function automatic logic [7:0] pick_code();
        return ready_codes[$urandom_range(0, ready_codes.size() - 1)];
    endfunction

    function automatic logic [4:0] safe_length(int ln);
        int p;
        p = 0;
        while (p < CHARS && chars_set[ln][p]) begin
            p++;
        end
        if (p == CHARS && $urandom_range(0, 2) == 0) begin
            return 5'($urandom_range(CHARS + 1, MAX_LEN));
        end
        return 5'($urandom_range(0, p));
    endfunction

    task automatic line_job();
        t_panel_cmd c;
        int ln;
        int n;
        int k;
        ln = $urandom_range(0, LINES - 1);
        n = ($urandom_range(0, 3) == 0) ? CHARS : $urandom_range(0, CHARS);
        for (k = 0; k < n; k++) begin
            c = noise_cmd();
            c.op = tlr_pkg::OP_WRITE;
            c.line = 3'(ln);
            c.column = 5'(k);
            c.char_code = pick_code();
            send_cmd(c, 1'b0, '0);
        end
        c = noise_cmd();
        c.op = tlr_pkg::OP_COMMIT;
        c.line = 3'(ln);
        c.line_length = (n == CHARS && $urandom_range(0, 1) == 1) ?
                        5'($urandom_range(CHARS + 1, MAX_LEN)) : 5'(n);
        send_cmd(c, 1'b0, '0);
    endtask

    task automatic font_glyph();
        t_panel_cmd c;
        logic [7:0] code;
        int k;
        code = 8'($urandom_range(0, 255));
        for (k = 0; k < GLYPH_W; k++) begin
            c = noise_cmd();
            c.op = tlr_pkg::OP_FONT;
            c.char_code = code;
            c.glyph_column = 3'(k);
            send_cmd(c, 1'b0, '0);
        end
        if ($urandom_range(0, 3) == 0) begin
            c = noise_cmd();
            c.op = tlr_pkg::OP_FONT;
            c.char_code = code;
            c.glyph_column = 3'($urandom_range(GLYPH_W, MAX_GCOL));
            send_cmd(c, 1'b0, '0);
        end
    endtask

    task automatic random_action();
        t_panel_cmd c;
        int pick;
        int n;
        pick = $urandom_range(0, 99);
        c = noise_cmd();
        if (pick < 45) begin
            n = ($urandom_range(0, 7) == 0) ? 130 : $urandom_range(1, 40);
            repeat (n) send_cmd(noise_cmd(), 1'b0, '0);
        end else if (pick < 70) begin
            line_job();
        end else if (pick < 80) begin
            font_glyph();
        end else begin
            if (pick < 88) begin
                c.op = tlr_pkg::OP_WRITE;
                c.char_code = pick_code();
            end else if (pick < 94) begin
                c.op = tlr_pkg::OP_COMMIT;
                c.line_length = safe_length(int'(c.line));
            end else if (pick < 97) begin
                c.op = 3'($urandom_range(OP_RSVD_FIRST, OP_RSVD_LAST));
            end else if (pick < 98) begin
                c.op = tlr_pkg::OP_CLEAR;
            end else begin
                c.op = tlr_pkg::OP_FONT;
            end
            send_cmd(c, 1'b0, '0);
        end
    endtask

    initial begin
        t_panel_cmd c;
        int phase;
        int target;
        int r;
        int k;

        for (r = 0; r < LINES; r++) begin
            row_len[r] = '0;
            row_attr[r] = '0;
            chars_set[r] = '0;
        end
        for (r = 0; r < 256; r++) begin
            glyph_cols_seen[r] = '0;
        end
        row_dirty = '0;
        active_row = NO_ROW;
        page_due = 1'b0;
        addr_due = 1'b0;
        pixel_pos = '0;

        // A write row with several repeats fills consecutive columns.
        script.push_back(plain_row(tlr_pkg::OP_STEP, 0, 0, 0, 0, '0, 0, 0, 1));
        script.push_back(plain_row(OP_RSVD_FIRST, 7, 31, 255, 31, '1, 7, 255, 1));
        script.push_back(plain_row(OP_RSVD_LAST, 0, 0, 0, 0, '0, 0, 0, 1));
        script.push_back(plain_row(tlr_pkg::OP_FONT, 0, 0, 8'hFF, 0, '0, 0, 8'h00, 1));
        script.push_back(plain_row(tlr_pkg::OP_FONT, 0, 0, 8'hFF, 0, '0, 1, 8'hFF, 1));
        script.push_back(plain_row(tlr_pkg::OP_FONT, 0, 0, 8'hFF, 0, '0, 2, 8'h81, 1));
        script.push_back(plain_row(tlr_pkg::OP_FONT, 0, 0, 8'hFF, 0, '0, 3, 8'h7E, 1));
        script.push_back(plain_row(tlr_pkg::OP_FONT, 0, 0, 8'hFF, 0, '0, 4, 8'h55, 1));
        script.push_back(plain_row(tlr_pkg::OP_FONT, 0, 0, 8'hFF, 0, '0, 5, 8'hAA, 1));
        script.push_back(plain_row(tlr_pkg::OP_FONT, 0, 0, 8'h00, 0, '0, MAX_GCOL, 8'h33, 1));
        script.push_back(plain_row(tlr_pkg::OP_WRITE, 7, CHARS - 1, 8'hFF, 0, '0, 0, 0, 1));
        script.push_back(plain_row(tlr_pkg::OP_WRITE, 7, MAX_LEN, 8'hFF, 0, '0, 0, 0, 1));
        script.push_back(plain_row(tlr_pkg::OP_COMMIT, 7, 0, 0, 0, A_CENTER | A_INV_ALL,
                                   0, 0, 1));
        script.push_back(typed_steps(1, tlr_pkg::BK_PAGE, tlr_pkg::CS_BOTH, 8'd7));
        script.push_back(typed_steps(1, tlr_pkg::BK_COLUMN, tlr_pkg::CS_BOTH, 8'd0));
        script.push_back(typed_steps(tlr_pkg::HALF_WIDTH, tlr_pkg::BK_DATA, tlr_pkg::CS_LEFT,
                                     tlr_pkg::FILL_ON));
        script.push_back(typed_steps(tlr_pkg::HALF_WIDTH, tlr_pkg::BK_DATA, tlr_pkg::CS_RIGHT,
                                     tlr_pkg::FILL_ON));
        script.push_back(plain_row(tlr_pkg::OP_WRITE, 0, 0, 8'hFF, 0, '0, 0, 0, CHARS));
        script.push_back(plain_row(tlr_pkg::OP_COMMIT, 0, 0, 0, MAX_LEN,
                                   A_CENTER | A_INV_TEXT, 0, 0, 1));
        script.push_back(plain_row(tlr_pkg::OP_STEP, 0, 0, 0, 0, '0, 0, 0, 40));
        script.push_back(plain_row(tlr_pkg::OP_COMMIT, 0, 0, 0, 10, A_INV_ALL, 0, 0, 1));
        script.push_back(plain_row(tlr_pkg::OP_STEP, 0, 0, 0, 0, '0, 0, 0, 90));
        script.push_back(plain_row(tlr_pkg::OP_STEP, 0, 0, 0, 0, '0, 0, 0, 1));
        script.push_back(plain_row(tlr_pkg::OP_CLEAR, 0, 0, 0, 0, '0, 0, 0, 1));
        script.push_back(typed_steps(1, tlr_pkg::BK_PAGE, tlr_pkg::CS_BOTH, 8'd0));

        tx_idle_pct = 36;
        rx_idle_pct = 45;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (r = 0; r < script.size(); r++) begin
            for (k = 0; k < int'(script[r].reps); k++) begin
                c = script[r].cmd;
                if (c.op == tlr_pkg::OP_WRITE) begin
                    c.column = c.column + 5'(k);
                end
                send_cmd(c, script[r].given, script[r].word);
            end
        end

        for (phase = 0; phase < 3; phase++) begin
            tx_idle_pct = (phase == 0) ? 36 : (phase == 1) ? 45 : 0;
            rx_idle_pct = (phase == 0) ? 45 : (phase == 1) ? 36 : 0;
            target = useful_items + ITEMS_PER_PHASE;
            while (useful_items < target) begin
                random_action();
            end
            hold_until_drained();
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (bus_words_due.size() != 0) begin
            mismatches++;
        end
        $display("Run covered %0d command words, %0d bus words checked, %0d full line refreshes.",
                 useful_items, bus_words_checked, lines_refreshed);
        $display("Font held %0d complete glyphs; %0d mismatches counted.",
                 ready_codes.size(), mismatches);
        if (mismatches == 0) begin
            $display("text_line_display_refresher: match");
        end else begin
            $display("text_line_display_refresher: mismatch");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Run timed out with %0d bus words still due.", bus_words_due.size());
        $display("text_line_display_refresher: mismatch");
        $finish;
    end

endmodule
